/* rtl/fhdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhdf_pkg - shared types and constants for the FNV-1a duplicate filter
// Action codes, FNV-1a 64-bit constants, the byte fold function and the
// command struct passed to the hash unit.
// ----------------------------------------------------------------------------
package fhdf_pkg;

  localparam logic [1:0] ACT_ABSORB   = 2'd0;
  localparam logic [1:0] ACT_FINAL    = 2'd1;
  localparam logic [1:0] ACT_REMEMBER = 2'd2;

  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic [7:0] data;
  } hash_cmd_t;

  // Fold one byte: xor into the low bits, multiply by the prime mod 2^64.
  // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

/* rtl/fhdf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhdf_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fhdf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/fhdf_hasher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhdf_hasher - running FNV-1a 64-bit hash
// Holds the running and the last finished hash; folds one byte per request.
// ----------------------------------------------------------------------------
module fhdf_hasher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fhdf_pkg::hash_cmd_t cmd,
  output logic              [63:0] finished_hash
);

  logic [63:0] running_r;
  logic [63:0] running_nxt;
  logic [63:0] finished_r;
  logic [63:0] finished_nxt;
  logic [63:0] folded;

  assign folded = fhdf_pkg::fnv_fold(running_r, cmd.data);

  always_comb begin
    running_nxt  = running_r;
    finished_nxt = finished_r;
    if (cmd.absorb) begin
      running_nxt = folded;
    end else if (cmd.finish) begin
      finished_nxt = folded;
      running_nxt  = fhdf_pkg::FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= fhdf_pkg::FNV_BASIS;
      finished_r <= '0;
    end else begin
      running_r  <= running_nxt;
      finished_r <= finished_nxt;
    end
  end

  assign finished_hash = finished_r;

endmodule
`default_nettype wire

/* rtl/fnv_hash_duplicate_filter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnv_hash_duplicate_filter_top - FNV-1a 64-bit hash with recent-hash filter
// Hashes message bytes and flags finished hashes already held in a ring.
// ----------------------------------------------------------------------------
// Feed message bytes one request at a time. An absorb request folds the byte
// into the running FNV-1a 64-bit hash; a final request folds its byte, reports
// the finished hash on the result channel with a duplicate flag, and restarts
// the running hash at the offset basis. A remember request stores the last
// finished hash into the history ring at the write slot and advances the slot,
// wrapping after HISTORY_DEPTH entries. Absorb, remember and the unused code
// leave the input unstalled. A final request stalls the input once accepted,
// while the check runs over the N ring entries written since reset (at most
// HISTORY_DEPTH): the ring sits in one RAM with a single read port, and the
// check scans the written entries one per cycle. If the previous result
// still sits unclaimed in the output register, the input stays stalled past
// that until the consumer takes it. A fill count marks which entries are
// valid, so reset needs no clearing pass. A finished result waits in an output
// register; absorb and remember requests keep flowing meanwhile. Zero entries
// count as empty, so a hash of zero is never a duplicate.
// ----------------------------------------------------------------------------
module fnv_hash_duplicate_filter_top #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] out_hash_value,
  output logic             out_is_duplicate
);

  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                issue_r, issue_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                dup_r, dup_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [63:0]         out_hash_r, out_hash_nxt;
  logic                out_dup_r, out_dup_nxt;

  logic                in_fire;
  logic                out_free;
  logic                last_issue;
  logic                match;
  logic                dup_fin;

  fhdf_pkg::hash_cmd_t hcmd;
  logic [63:0]         finished_hash;

  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [63:0]         ram_rd_data;

  // Accept requests only while no check is in flight.
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign hcmd.absorb = in_fire && (in_action == fhdf_pkg::ACT_ABSORB);
  assign hcmd.finish = in_fire && (in_action == fhdf_pkg::ACT_FINAL);
  assign hcmd.data   = in_data_byte;

  fhdf_hasher u_hasher (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (hcmd),
    .finished_hash (finished_hash)
  );

  // History ring: written by remember, read by the duplicate scan.
  fhdf_ram #(
    .WIDTH (64),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_r),
    .wr_data (finished_hash),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rd_data)
  );

  // Last valid entry is fill-1; fill is nonzero whenever a scan runs.
  assign last_issue = (scan_idx_r == SLOT_W'(fill_r - CNT_W'(1)));
  assign match      = (ram_rd_data != '0) && (ram_rd_data == finished_hash);
  assign dup_fin    = dup_r | match;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    scan_idx_nxt  = scan_idx_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    out_dup_nxt   = out_dup_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;

    // Drop the result once the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            fhdf_pkg::ACT_FINAL: begin
              dup_nxt      = 1'b0;
              scan_idx_nxt = '0;
              if (fill_r == '0) begin
                state_nxt = S_HOLD;
              end else begin
                state_nxt = S_SCAN;
                issue_nxt = 1'b1;
              end
            end
            fhdf_pkg::ACT_REMEMBER: begin
              // Store the last finished hash and advance the slot.
              ram_wr_en = 1'b1;
              slot_nxt  = (slot_r == LAST_SLOT) ? '0 : SLOT_W'(slot_r + 1'b1);
              if (fill_r != FULL_CNT) begin
                fill_nxt = CNT_W'(fill_r + 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; compare each entry as the RAM returns it.
        ram_rd_en   = issue_r;
        cmp_vld_nxt = issue_r;
        if (issue_r) begin
          scan_idx_nxt = SLOT_W'(scan_idx_r + 1'b1);
          if (last_issue) begin
            issue_nxt = 1'b0;
          end
        end
        if (cmp_vld_r) begin
          dup_nxt = dup_fin;
          if (!issue_r) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_hash_nxt  = finished_hash;
              out_dup_nxt   = dup_fin;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_HOLD;
            end
          end
        end
      end
      S_HOLD: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = finished_hash;
          out_dup_nxt   = dup_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      scan_idx_r  <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      scan_idx_r  <= scan_idx_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hash_r <= out_hash_nxt;
    out_dup_r  <= out_dup_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hash_value   = out_hash_r;
  assign out_is_duplicate = out_dup_r;

`ifndef ASSERT_OFF
  // A final request always starts a check.
  a_final_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_action == fhdf_pkg::ACT_FINAL)) |=> (state_r != S_IDLE))
    else $error("final request did not start a check");

  // Compares happen only inside a scan.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare outside of scan");

  // Fill count never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond ring depth");

  // Ring writes never overlap a scan.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_IDLE) && !ram_rd_en)
    else $error("ring write during scan");
`endif

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the FNV-1a duplicate filter
// Drives byte, final, remember and unused requests through the valid/stall
// input channel, predicts every finished hash and its duplicate flag with a
// bench-side copy of the hash state and history ring, and compares each
// accepted result in order. Runs a directed part, an output hold-off that
// backs the block up, and three random phases with varied idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RING_DEPTH   = 32;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int          LIMIT_CYCLES = 400000;
  // A final request scans up to RING_DEPTH entries; allow for twice that.
  localparam int          DRAIN_CYCLES = 2 * RING_DEPTH + 8;
  localparam int          PRINT_CAP    = 100;

  typedef struct packed {
    logic [63:0] hash;
    logic        dup;
  } digest_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action        = fhdf_pkg::ACT_ABSORB;
  logic [7:0]  in_data_byte     = 8'h00;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [63:0] out_hash_value;
  logic        out_is_duplicate;

  // Idling knobs, in percent per cycle, and the long output hold-off flag.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_on        = 1'b0;

  int   mismatches = 0;

  // Bench-side copy of the filter state.
  logic [63:0] acc_hash;
  logic [63:0] done_hash;
  logic [63:0] history [RING_DEPTH];
  int unsigned history_wr;

  // Finished hashes expected on the result channel, oldest first.
  digest_t pending_digests[$];

  fnv_hash_duplicate_filter_top #(
    .HISTORY_DEPTH(RING_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash_value  (out_hash_value),
    .out_is_duplicate(out_is_duplicate)
  );

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles; give up on a hung run long after the slowest correct one.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Hash and history prediction
  // --------------------------------------------------------------------------
  // Xor the byte into the low bits, then multiply by the prime mod 2^64.
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x * fhdf_pkg::FNV_PRIME;
  endfunction

  // Zero entries are empty slots and never match.
  function automatic logic history_hit(input logic [63:0] h);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (history[i] != 64'd0 && history[i] == h) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void filter_clear();
    acc_hash   = fhdf_pkg::FNV_BASIS;
    done_hash  = 64'd0;
    history_wr = 0;
    for (int i = 0; i < RING_DEPTH; i++) history[i] = 64'd0;
  endfunction

  // Advance the predicted state by one accepted request; queue a digest on final.
  function automatic void predict_digest(input logic [1:0] act, input logic [7:0] data);
    digest_t d;
    case (act)
      fhdf_pkg::ACT_ABSORB: begin
        acc_hash = fnv_mix(acc_hash, data);
      end
      fhdf_pkg::ACT_FINAL: begin
        d.hash    = fnv_mix(acc_hash, data);
        d.dup     = history_hit(d.hash);   // ring as it stands before this step
        done_hash = d.hash;
        acc_hash  = fhdf_pkg::FNV_BASIS;
        pending_digests.push_back(d);
      end
      fhdf_pkg::ACT_REMEMBER: begin
        history[history_wr] = done_hash;
        history_wr = (history_wr + 1) % RING_DEPTH;
      end
      default: ;  // unused code: no state change, no result
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, long hold-off, in-order compare
  // --------------------------------------------------------------------------
  // Stall at random, or hold solid while a hold-off is running.
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < PRINT_CAP)
      $display("ERROR %s: expected %h got %h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // Pop the oldest expected digest for each accepted result and compare fields.
  always @(posedge clk) begin : result_check
    digest_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, out_hash_value);
      end else begin
        want = pending_digests.pop_front();
        if (out_hash_value !== want.hash)
          report_mismatch("hash_value", want.hash, out_hash_value);
        if (out_is_duplicate !== want.dup)
          report_mismatch("is_duplicate", {63'd0, want.dup}, {63'd0, out_is_duplicate});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Idle at random, present one request, hold it until accepted, then predict.
  task automatic send_request(input logic [1:0] act, input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    predict_digest(act, data);
  endtask

  // Fold all but the last byte, then finish the message on the last one.
  task automatic send_message(input logic [7:0] msg[$]);
    for (int i = 0; i < msg.size(); i++)
      send_request((i == msg.size() - 1) ? fhdf_pkg::ACT_FINAL : fhdf_pkg::ACT_ABSORB,
                   msg[i]);
  endtask

  // Recurring messages, so the history ring sees repeats.
  function automatic logic [7:0] stock_byte(input int id, input int pos);
    return 8'((id * 73 + pos * 151 + 11) ^ (id << 4));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Walk the corner cases once with no idling on either side.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Remember before any finish: stores the zero reset hash, slot advances.
    send_request(fhdf_pkg::ACT_REMEMBER, 8'hA5);
    // Single-byte messages at the byte extremes; the zero entry must not match.
    send_request(fhdf_pkg::ACT_FINAL, 8'h00);
    send_request(fhdf_pkg::ACT_FINAL, 8'hFF);
    // Unused code is dropped, with both data extremes.
    send_request(ACT_UNUSED, 8'hFF);
    send_request(ACT_UNUSED, 8'h00);
    // Remember twice: the same hash lands in two slots.
    send_request(fhdf_pkg::ACT_FINAL, 8'h61);
    send_request(fhdf_pkg::ACT_REMEMBER, 8'h00);
    send_request(fhdf_pkg::ACT_REMEMBER, 8'hFF);
    // Same message again must flag as duplicate; remember it anyway.
    send_request(fhdf_pkg::ACT_FINAL, 8'h61);
    send_request(fhdf_pkg::ACT_REMEMBER, 8'h00);
    // Multi-byte message with extreme bytes, and an unused code in the middle.
    send_request(fhdf_pkg::ACT_ABSORB, 8'h00);
    send_request(fhdf_pkg::ACT_ABSORB, 8'hFF);
    send_request(ACT_UNUSED, 8'h55);
    send_request(fhdf_pkg::ACT_ABSORB, 8'h80);
    send_request(fhdf_pkg::ACT_FINAL, 8'h7F);
    // Check before store: first final misses, remembered, second final hits.
    send_request(fhdf_pkg::ACT_ABSORB, 8'h62);
    send_request(fhdf_pkg::ACT_FINAL, 8'h63);
    send_request(fhdf_pkg::ACT_REMEMBER, 8'h01);
    send_request(fhdf_pkg::ACT_ABSORB, 8'h62);
    send_request(fhdf_pkg::ACT_FINAL, 8'h63);
    send_request(fhdf_pkg::ACT_FINAL, 8'h61);
  endtask

  // Hold the result side for a long stretch while requests keep coming, so
  // the output register fills and the block stalls its input.
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        for (int i = 0; i < 60; i++) begin
          case ($urandom_range(0, 3))
            0:       send_request(fhdf_pkg::ACT_FINAL, 8'($urandom));
            1:       send_request(fhdf_pkg::ACT_REMEMBER, 8'($urandom));
            default: send_request(fhdf_pkg::ACT_ABSORB, 8'($urandom));
          endcase
        end
      end
    join
  endtask

  // Mostly well-formed messages, many recurring, plus stray and broken traffic.
  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    int          sent;
    int          len;
    int          id;
    int          pick;
    logic [7:0]  msg[$];
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        msg.delete();
        if ($urandom_range(0, 1)) begin
          id  = $urandom_range(0, 11);
          len = 1 + id % 5;
          for (int i = 0; i < len; i++) msg.push_back(stock_byte(id, i));
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) msg.push_back(8'($urandom));
        end
        send_message(msg);
        sent += len;
        if ($urandom_range(0, 1)) begin
          send_request(fhdf_pkg::ACT_REMEMBER, 8'($urandom));
          sent++;
        end
      end else if (pick < 85) begin
        send_request(fhdf_pkg::ACT_REMEMBER, 8'($urandom));
        sent++;
      end else if (pick < 93) begin
        // ignored by the block; not counted
        send_request(ACT_UNUSED, 8'($urandom));
      end else begin
        // broken message: a dangling prefix folded into whatever follows
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_request(fhdf_pkg::ACT_ABSORB, 8'($urandom));
        sent += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    filter_clear();
    // Hold reset low at the start, then release it once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_hold();
    test_random_traffic(400, 37, 86);
    test_random_traffic(400, 86, 37);
    test_random_traffic(400, 0, 0);

    // Drop valid, drain the expected results, then let the block settle.
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
